### src/assert_macros.svh
// Assertion macros used by the top-level RTL file of the reflectance block.
// Defining ASSERT_OFF compiles every assertion away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

### src/dfr_pkg.sv
// Constants and types of the dielectric Fresnel reflectance block.
// No dependencies.
package dfr_pkg;
    localparam int COS_W   = 16;
    localparam int MAG_W   = 15;
    localparam int ETA_W   = 14;
    localparam int REFL_W  = 16;
    localparam int FRAC_W  = 30;
    localparam int ROOT_STEPS = 2;
    localparam int DIV_STEPS  = 2;
    localparam logic [MAG_W-1:0]  ONE_Q14 = 15'd16384;
    localparam logic [ETA_W-1:0]  ETA_MIN = 14'd2048;
    localparam logic [ETA_W-1:0]  ETA_RESET = 14'd4096;
    localparam logic [REFL_W-1:0] ONE_Q15 = 16'd32768;
    localparam logic REG_ETA_OUTSIDE = 1'b0;
    localparam logic REG_ETA_INSIDE  = 1'b1;
    typedef logic [ETA_W-1:0] t_eta;
endpackage

### src/dfr_isqrt_pipe.sv
// Pipelined integer square root, a fixed number of root bits per stage.
// Depends on nothing but its parameters.
module dfr_isqrt_pipe #(
    parameter int IN_W   = 56,
    parameter int SIDE_W = 1,
    parameter int STEPS  = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_vld,
    input  logic [IN_W-1:0]       i_rad,
    input  logic [SIDE_W-1:0]     i_side,
    output logic                  o_vld,
    output logic [IN_W/2-1:0]     o_root,
    output logic [SIDE_W-1:0]     o_side
);
    localparam int ROOT_W = IN_W / 2;
    localparam int STAGES = ROOT_W / STEPS;
    localparam int REM_W  = ROOT_W + 2;

    logic              w_vld  [0:STAGES];
    logic [REM_W-1:0]  w_rem  [0:STAGES];
    logic [ROOT_W-1:0] w_root [0:STAGES];
    logic [IN_W-1:0]   w_rad  [0:STAGES];
    logic [SIDE_W-1:0] w_side [0:STAGES];

    assign w_vld[0]  = i_vld;
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;
    assign w_rad[0]  = i_rad;
    assign w_side[0] = i_side;

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        logic [REM_W-1:0]  n_rem;
        logic [ROOT_W-1:0] n_root;
        logic [IN_W-1:0]   n_rad;
        logic [REM_W-1:0]  trial;
        logic              r_vld;
        logic [REM_W-1:0]  r_rem;
        logic [ROOT_W-1:0] r_root;
        logic [IN_W-1:0]   r_rad;
        logic [SIDE_W-1:0] r_side;

        always_comb begin
            n_rem  = w_rem[s];
            n_root = w_root[s];
            n_rad  = w_rad[s];
            trial  = '0;
            for (int j = 0; j < STEPS; j++) begin
                n_rem = {n_rem[REM_W-3:0], n_rad[IN_W-1 -: 2]};
                trial = {n_root, 2'b01};
                if (n_rem >= trial) begin
                    n_rem  = n_rem - trial;
                    n_root = {n_root[ROOT_W-2:0], 1'b1};
                end else begin
                    n_root = {n_root[ROOT_W-2:0], 1'b0};
                end
                n_rad = {n_rad[IN_W-3:0], 2'b00};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else begin
                r_vld <= w_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_rad  <= n_rad;
            r_side <= w_side[s];
        end

        assign w_vld[s+1]  = r_vld;
        assign w_rem[s+1]  = r_rem;
        assign w_root[s+1] = r_root;
        assign w_rad[s+1]  = r_rad;
        assign w_side[s+1] = r_side;
    end

    assign o_vld  = w_vld[STAGES];
    assign o_root = w_root[STAGES];
    assign o_side = w_side[STAGES];
endmodule

### src/dfr_div_pipe.sv
// Pipelined fractional divider, several lanes side by side, saturating at one.
// Depends on nothing but its parameters.
module dfr_div_pipe #(
    parameter int LANES  = 2,
    parameter int DEN_W  = 44,
    parameter int Q_W    = 30,
    parameter int STEPS  = 2,
    parameter int SIDE_W = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_vld,
    input  logic [LANES-1:0][DEN_W-1:0] i_num,
    input  logic [LANES-1:0][DEN_W-1:0] i_den,
    input  logic [SIDE_W-1:0]           i_side,
    output logic                        o_vld,
    output logic [LANES-1:0][Q_W:0]     o_quot,
    output logic [SIDE_W-1:0]           o_side
);
    localparam int STAGES = Q_W / STEPS;

    logic                        w_vld  [0:STAGES];
    logic [LANES-1:0][DEN_W-1:0] w_r    [0:STAGES];
    logic [LANES-1:0][DEN_W-1:0] w_den  [0:STAGES];
    logic [LANES-1:0][Q_W-1:0]   w_q    [0:STAGES];
    logic [LANES-1:0]            w_sat  [0:STAGES];
    logic [SIDE_W-1:0]           w_side [0:STAGES];

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w_sat[0][l] = (i_den[l] == '0) || (i_num[l] >= i_den[l]);
            w_r[0][l]   = w_sat[0][l] ? '0 : i_num[l];
        end
    end

    assign w_vld[0]  = i_vld;
    assign w_den[0]  = i_den;
    assign w_q[0]    = '0;
    assign w_side[0] = i_side;

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        logic [LANES-1:0][DEN_W-1:0] n_r;
        logic [LANES-1:0][Q_W-1:0]   n_q;
        logic [DEN_W:0]              t;
        logic                        r_vld;
        logic [LANES-1:0][DEN_W-1:0] r_r;
        logic [LANES-1:0][DEN_W-1:0] r_den;
        logic [LANES-1:0][Q_W-1:0]   r_q;
        logic [LANES-1:0]            r_sat;
        logic [SIDE_W-1:0]           r_side;

        always_comb begin
            n_r = w_r[s];
            n_q = w_q[s];
            t   = '0;
            for (int l = 0; l < LANES; l++) begin
                for (int j = 0; j < STEPS; j++) begin
                    t = {n_r[l], 1'b0};
                    if (t >= {1'b0, w_den[s][l]}) begin
                        t = t - {1'b0, w_den[s][l]};
                        n_q[l] = {n_q[l][Q_W-2:0], 1'b1};
                    end else begin
                        n_q[l] = {n_q[l][Q_W-2:0], 1'b0};
                    end
                    n_r[l] = t[DEN_W-1:0];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else begin
                r_vld <= w_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            r_r    <= n_r;
            r_den  <= w_den[s];
            r_q    <= n_q;
            r_sat  <= w_sat[s];
            r_side <= w_side[s];
        end

        assign w_vld[s+1]  = r_vld;
        assign w_r[s+1]    = r_r;
        assign w_den[s+1]  = r_den;
        assign w_q[s+1]    = r_q;
        assign w_sat[s+1]  = r_sat;
        assign w_side[s+1] = r_side;
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_quot[l] = w_sat[STAGES][l] ? {1'b1, {Q_W{1'b0}}} : {1'b0, w_q[STAGES][l]};
        end
    end

    assign o_vld  = w_vld[STAGES];
    assign o_side = w_side[STAGES];
endmodule

### src/dielectric_fresnel_reflectance.sv
// Top level of the dielectric Fresnel reflectance pipeline.
// Depends on dfr_pkg, dfr_isqrt_pipe, dfr_div_pipe and assert_macros.svh.
//
// One item is taken in every cycle and busy never rises. Each result passes
// the squares, sine test, radicand, square root, products, divider, ratio
// squares and output registers and is shown on o_valid for one cycle; the
// receiver cannot stall it. The square root resolves two root bits per stage
// over 14 stages, the divider two quotient bits per lane and stage over 15 stages.
// The index registers must only be written while no item is in flight.
`include "assert_macros.svh"
module dielectric_fresnel_reflectance (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [dfr_pkg::COS_W-1:0] i_cos_incident,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_idx,
    input  logic [dfr_pkg::ETA_W-1:0]    i_cfg_data,
    output logic                         o_valid,
    output logic [dfr_pkg::REFL_W-1:0]   o_reflectance,
    output logic                         o_total_reflection
);
    localparam int MAG_W  = dfr_pkg::MAG_W;
    localparam int ETA_W  = dfr_pkg::ETA_W;
    localparam int SQ_W   = 2 * ETA_W;
    localparam int RAD_W  = 56;
    localparam int ROOT_W = RAD_W / 2;
    localparam int A_W    = SQ_W + MAG_W;
    localparam int DEN_W  = A_W + 1;
    localparam int Q_W    = dfr_pkg::FRAC_W;
    localparam int SIDE_W = 1 + MAG_W + SQ_W;

    dfr_pkg::t_eta r_eta_out, r_eta_in;
    dfr_pkg::t_eta e0, e1;
    logic [15:0]   mag;
    logic [MAG_W-1:0] c_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eta_out <= dfr_pkg::ETA_RESET;
            r_eta_in  <= dfr_pkg::ETA_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == dfr_pkg::REG_ETA_OUTSIDE) begin
                r_eta_out <= i_cfg_data;
            end else begin
                r_eta_in <= i_cfg_data;
            end
        end
    end

    assign busy = 1'b0;
    assign e0 = (r_eta_out < dfr_pkg::ETA_MIN) ? dfr_pkg::ETA_MIN : r_eta_out;
    assign e1 = (r_eta_in < dfr_pkg::ETA_MIN) ? dfr_pkg::ETA_MIN : r_eta_in;
    assign mag = i_cos_incident[15] ? (16'd0 - i_cos_incident) : i_cos_incident;
    assign c_in = (mag > {1'b0, dfr_pkg::ONE_Q14}) ? dfr_pkg::ONE_Q14 : mag[MAG_W-1:0];

    // Stage 1: squares.
    logic             r1_vld;
    logic [29:0]      r1_cc;
    logic [SQ_W-1:0]  r1_ee0, r1_ee1;
    logic [MAG_W-1:0] r1_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_cc  <= 30'(c_in * c_in);
        r1_ee0 <= SQ_W'(e0 * e0);
        r1_ee1 <= SQ_W'(e1 * e1);
        r1_c   <= c_in;
    end

    // Stage 2: scaled squared sine against the transmitted limit.
    logic             r2_vld;
    logic [RAD_W:0]   r2_lhs;
    logic [RAD_W-1:0] r2_rhs;
    logic [SQ_W-1:0]  r2_ee1;
    logic [MAG_W-1:0] r2_c;
    logic [28:0]      s2;

    assign s2 = 29'(30'd268435456 - r1_cc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_lhs <= (RAD_W+1)'(r1_ee0 * s2);
        r2_rhs <= {r1_ee1, 28'd0};
        r2_ee1 <= r1_ee1;
        r2_c   <= r1_c;
    end

    // Stage 3: total internal reflection test and radicand.
    logic             r3_vld, r3_tir;
    logic [RAD_W-1:0] r3_rad;
    logic [SQ_W-1:0]  r3_ee1;
    logic [MAG_W-1:0] r3_c;
    logic             tir;

    assign tir = r2_lhs > {1'b0, r2_rhs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_tir <= tir;
        r3_rad <= tir ? '0 : (r2_rhs - r2_lhs[RAD_W-1:0]);
        r3_ee1 <= r2_ee1;
        r3_c   <= r2_c;
    end

    logic              sq_vld;
    logic [ROOT_W-1:0] sq_root;
    logic [SIDE_W-1:0] sq_side;

    dfr_isqrt_pipe #(
        .IN_W   (RAD_W),
        .SIDE_W (SIDE_W),
        .STEPS  (dfr_pkg::ROOT_STEPS)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r3_vld),
        .i_rad   (r3_rad),
        .i_side  ({r3_tir, r3_c, r3_ee1}),
        .o_vld   (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // Stage M: numerator and denominator products.
    logic              rm_vld, rm_tir;
    logic [A_W-1:0]    rm_a, rm_b;
    logic [29:0]       rm_d;
    logic [ROOT_W-1:0] rm_f;
    logic              s_tir;
    logic [MAG_W-1:0]  s_c;
    logic [SQ_W-1:0]   s_ee1;

    assign {s_tir, s_c, s_ee1} = sq_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rm_vld <= 1'b0;
        end else begin
            rm_vld <= sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        rm_tir <= s_tir;
        rm_a   <= A_W'(s_ee1 * s_c);
        rm_b   <= A_W'(e0 * sq_root);
        rm_d   <= 30'(e0 * s_c);
        rm_f   <= sq_root;
    end

    logic [1:0][DEN_W-1:0] div_num, div_den;
    logic [29:0]           df_diff;

    assign df_diff = (rm_d >= {2'b00, rm_f}) ? (rm_d - {2'b00, rm_f})
                                              : ({2'b00, rm_f} - rm_d);
    assign div_num[0] = (rm_a >= rm_b) ? {1'b0, rm_a - rm_b} : {1'b0, rm_b - rm_a};
    assign div_den[0] = {1'b0, rm_a} + {1'b0, rm_b};
    assign div_num[1] = DEN_W'(df_diff);
    assign div_den[1] = DEN_W'(rm_d) + DEN_W'(rm_f);

    logic            dv_vld, dv_tir;
    logic [1:0][Q_W:0] dv_quot;

    dfr_div_pipe #(
        .LANES  (2),
        .DEN_W  (DEN_W),
        .Q_W    (Q_W),
        .STEPS  (dfr_pkg::DIV_STEPS),
        .SIDE_W (1)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (rm_vld),
        .i_num   (div_num),
        .i_den   (div_den),
        .i_side  (rm_tir),
        .o_vld   (dv_vld),
        .o_quot  (dv_quot),
        .o_side  (dv_tir)
    );

    // Squares of both ratios.
    logic                r5_vld, r5_tir;
    logic [2*Q_W+1:0]    r5_pp, r5_qq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else begin
            r5_vld <= dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r5_tir <= dv_tir;
        r5_pp  <= dv_quot[0] * dv_quot[0];
        r5_qq  <= dv_quot[1] * dv_quot[1];
    end

    // Mean of the squares, rounded half up.
    logic [2*Q_W+2:0] sum;

    assign sum = {1'b0, r5_pp} + {1'b0, r5_qq} + ((2*Q_W+3)'(1) << 45);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        o_total_reflection <= r5_tir;
        o_reflectance      <= r5_tir ? dfr_pkg::ONE_Q15 : sum[61:46];
    end

    `ASSERT_IMPLY(a_tir_full, i_clk, i_rst_n, o_valid && o_total_reflection,
                  o_reflectance == dfr_pkg::ONE_Q15)
    `ASSERT_IMPLY(a_refl_range, i_clk, i_rst_n, o_valid, o_reflectance <= dfr_pkg::ONE_Q15)
    `ASSERT_IMPLY(a_reset_flush, i_clk, i_rst_n, !$past(i_rst_n), !o_valid && !r5_vld)
    `ASSERT_NEVER(a_never_busy, i_clk, i_rst_n, busy)
endmodule
